// File: hw/rtl/cnms_pkg.sv
// Shared types and constants of the Canny non-maximum suppression unit.
// Depends on nothing; all files of the unit but cnms_ram import it.
`default_nettype none

package cnms_pkg;

  // Default line buffer depth, the widest frame the unit accepts.
  localparam int unsigned CNMS_MAX_WIDTH = 1024;

  // Field widths of the stream and configuration payloads.
  localparam int unsigned MAG_W      = 16;
  localparam int unsigned ANG_W      = 11;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned COL_W      = 10;
  localparam int unsigned WIDTH_W    = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  // Register reset values, smallest usable frame dimension and row limit.
  localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [ROW_W-1:0]   HEIGHT_RESET = 12'd480;
  localparam logic [ROW_W-1:0]   MIN_DIM      = 12'd3;
  localparam logic [ROW_W-1:0]   ROW_SAT      = 12'd4095;

  // Angle thresholds in quarter degrees: 22.5, 67.5, 112.5 and 157.5 degrees.
  localparam logic [11:0] ANG_22_5   = 12'd90;
  localparam logic [11:0] ANG_67_5   = 12'd270;
  localparam logic [11:0] ANG_112_5  = 12'd450;
  localparam logic [11:0] ANG_157_5  = 12'd630;
  // 180 and 360 degrees, used to fold negative angles.
  localparam logic [11:0] ANG_180    = 12'd720;
  localparam logic [11:0] ANG_360    = 12'd1440;

  // Neighbour pair picked by the gradient direction.
  typedef enum logic [1:0] {
    DIR_HORIZONTAL = 2'd0,
    DIR_DIAG_DOWN  = 2'd1,
    DIR_VERTICAL   = 2'd2,
    DIR_DIAG_UP    = 2'd3
  } dir_t;

  // One accepted item together with the position decisions made at acceptance.
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [ANG_W-1:0] ang;
    logic             emit;
    logic             border;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } scan_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/cnms_if.sv
// Handshake interfaces of the unit: input stream, result stream, configuration writes.
// Depends on cnms_pkg for the payload widths.
`default_nettype none

interface cnms_in_if;
  import cnms_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic [MAG_W-1:0]        grad_magnitude;
  logic signed [ANG_W-1:0] grad_angle;

  modport source (output valid, output cmd, output grad_magnitude, output grad_angle,
                  input ready);
  modport sink   (input valid, input cmd, input grad_magnitude, input grad_angle,
                  output ready);
endinterface

interface cnms_out_if;
  import cnms_pkg::*;
  logic             valid;
  logic             ready;
  logic [MAG_W-1:0] kept_magnitude;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic             frame_last;

  modport source (output valid, output kept_magnitude, output out_row, output out_col,
                  output frame_last, input ready);
  modport sink   (input valid, input kept_magnitude, input out_row, input out_col,
                  input frame_last, output ready);
endinterface

interface cnms_cfg_if;
  import cnms_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/cnms_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
`default_nettype none

module cnms_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/cnms_scan_ctrl.sv
// Raster position tracking and configuration registers of the unit.
// Depends on cnms_pkg; feeds the line buffer read address and cnms_suppress.
`default_nettype none

module cnms_scan_ctrl #(
  parameter int unsigned MAX_WIDTH = cnms_pkg::CNMS_MAX_WIDTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_write,
  input  wire logic [cnms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cnms_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_accept,
  input  wire logic                             in_cmd,
  input  wire logic [cnms_pkg::MAG_W-1:0]       in_mag,
  input  wire logic [cnms_pkg::ANG_W-1:0]       in_ang,
  output logic      [$clog2(MAX_WIDTH)-1:0]     rd_addr,
  output cnms_pkg::scan_item_t                  item,
  output logic                                  restart
);
  import cnms_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned EW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;

  logic [WIDTH_W-1:0] width_r, width_nxt;
  logic [ROW_W-1:0]   height_r, height_nxt;
  logic [CW-1:0]      c_r, c_nxt;
  logic [ROW_W-1:0]   r_r, r_nxt;
  logic [CW-1:0]      ocol_r, ocol_nxt;
  logic [ROW_W-1:0]   orow_r, orow_nxt;

  logic [EW-1:0]    w_raw, w_eff, c_inc, oc_inc, oc_ext;
  logic [ROW_W-1:0] h_eff;
  logic             emit, border, last_pos;

  always_comb begin
    w_raw = EW'(width_r);
    if (w_raw < EW'(MIN_DIM)) begin
      w_eff = EW'(MIN_DIM);
    end else if (w_raw > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    h_eff = (height_r < MIN_DIM) ? MIN_DIM : height_r;

    emit     = (r_r >= 12'd2) || ((r_r == 12'd1) && (c_r != '0));
    oc_ext   = EW'(ocol_r);
    last_pos = (orow_r == h_eff - 12'd1) && (oc_ext == w_eff - EW'(1));
    border   = (orow_r == '0) || (orow_r == h_eff - 12'd1) || (ocol_r == '0) ||
               (oc_ext == w_eff - EW'(1));
    c_inc    = EW'(c_r) + EW'(1);
    oc_inc   = oc_ext + EW'(1);
  end

  always_comb begin
    item.mag    = in_cmd ? '0 : in_mag;
    item.ang    = in_cmd ? '0 : in_ang;
    item.emit   = emit;
    item.border = border;
    item.last   = emit && last_pos;
    item.row    = orow_r;
    item.col    = COL_W'(ocol_r);
  end

  assign rd_addr = c_r;
  assign restart = cfg_write && ((cfg_index == CFG_IMAGE_WIDTH) ||
                                 (cfg_index == CFG_IMAGE_HEIGHT));

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    c_nxt      = c_r;
    r_nxt      = r_r;
    ocol_nxt   = ocol_r;
    orow_nxt   = orow_r;
    if (cfg_write && (cfg_index == CFG_IMAGE_WIDTH)) begin
      width_nxt = cfg_data[WIDTH_W-1:0];
    end
    if (cfg_write && (cfg_index == CFG_IMAGE_HEIGHT)) begin
      height_nxt = cfg_data;
    end
    priority if (restart || (in_accept && emit && last_pos)) begin
      c_nxt    = '0;
      r_nxt    = '0;
      ocol_nxt = '0;
      orow_nxt = '0;
    end else if (in_accept) begin
      if (c_inc >= w_eff) begin
        c_nxt = '0;
        if (r_r != ROW_SAT) begin
          r_nxt = r_r + 12'd1;
        end
      end else begin
        c_nxt = CW'(c_inc);
      end
      if (emit) begin
        if (oc_inc >= w_eff) begin
          ocol_nxt = '0;
          orow_nxt = orow_r + 12'd1;
        end else begin
          ocol_nxt = CW'(oc_inc);
        end
      end
    end else begin
      c_nxt = c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      c_r      <= '0;
      r_r      <= '0;
      ocol_r   <= '0;
      orow_r   <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      c_r      <= c_nxt;
      r_r      <= r_nxt;
      ocol_r   <= ocol_nxt;
      orow_r   <= orow_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/cnms_suppress.sv
// Line buffer write-back, 3x3 window and suppression compare with the result register.
// Depends on cnms_pkg; works on the read data of the two line buffer RAMs.
`default_nettype none

module cnms_suppress #(
  parameter int unsigned MAX_WIDTH = cnms_pkg::CNMS_MAX_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           restart,
  input  wire logic                           in_accept,
  output logic                                in_ready,
  input  wire cnms_pkg::scan_item_t           item,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]   rd_addr,
  input  wire logic [2*cnms_pkg::MAG_W-1:0]   mag_rdata,
  input  wire logic [cnms_pkg::ANG_W-1:0]     ang_rdata,
  output logic                                wr_en,
  output logic      [$clog2(MAX_WIDTH)-1:0]   wr_addr,
  output logic      [2*cnms_pkg::MAG_W-1:0]   mag_wdata,
  output logic      [cnms_pkg::ANG_W-1:0]     ang_wdata,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [cnms_pkg::MAG_W-1:0]     out_kept,
  output logic      [cnms_pkg::ROW_W-1:0]     out_row,
  output logic      [cnms_pkg::COL_W-1:0]     out_col,
  output logic                                out_last
);
  import cnms_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  logic             s1_valid_r, s1_valid_nxt;
  scan_item_t       s1_item_r;
  logic [CW-1:0]    s1_addr_r;
  logic [MAG_W-1:0] win_r [6];
  logic [ANG_W-1:0] angd_r;
  logic             out_valid_r, out_valid_nxt;
  logic [MAG_W-1:0] out_kept_r;
  logic [ROW_W-1:0] out_row_r;
  logic [COL_W-1:0] out_col_r;
  logic             out_last_r;

  logic             s1_adv;
  logic [MAG_W-1:0] up, mid, centre, q, s, kept;
  logic [11:0]      ang_ext, ang_fold;
  dir_t             dir;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  assign up  = mag_rdata[2*MAG_W-1:MAG_W];
  assign mid = mag_rdata[MAG_W-1:0];

  // The row shift happens in the RAM word: the old newest row moves to the upper half.
  assign wr_en     = s1_adv;
  assign wr_addr   = s1_addr_r;
  assign mag_wdata = {mid, s1_item_r.mag};
  assign ang_wdata = s1_item_r.ang;

  always_comb begin
    ang_ext = {angd_r[ANG_W-1], angd_r};
    if (angd_r[ANG_W-1]) begin
      ang_fold = ang_ext + ANG_360;
      if (ang_fold >= ANG_180) begin
        ang_fold = ang_fold - ANG_180;
      end
    end else begin
      ang_fold = ang_ext;
    end
    priority if ((ang_fold <= ANG_22_5) || (ang_fold > ANG_157_5)) begin
      dir = DIR_HORIZONTAL;
    end else if (ang_fold <= ANG_67_5) begin
      dir = DIR_DIAG_DOWN;
    end else if (ang_fold <= ANG_112_5) begin
      dir = DIR_VERTICAL;
    end else begin
      dir = DIR_DIAG_UP;
    end
  end

  // Window layout: win_r[0..2] is the oldest column, win_r[3..5] the centre column,
  // each top to bottom; the newest column comes straight from the RAM and the input.
  always_comb begin
    centre = win_r[4];
    unique case (dir)
      DIR_HORIZONTAL: begin
        q = win_r[1];
        s = mid;
      end
      DIR_DIAG_DOWN: begin
        q = s1_item_r.mag;
        s = win_r[0];
      end
      DIR_VERTICAL: begin
        q = win_r[3];
        s = win_r[5];
      end
      DIR_DIAG_UP: begin
        q = win_r[2];
        s = up;
      end
      default: begin
        q = '0;
        s = '0;
      end
    endcase
    if (!s1_item_r.border && ((centre < q) || (centre < s))) begin
      kept = '0;
    end else begin
      kept = centre;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_item_r.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      angd_r      <= '0;
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (restart || (s1_adv && s1_item_r.last)) begin
        angd_r <= '0;
        for (int i = 0; i < 6; i++) begin
          win_r[i] <= '0;
        end
      end else if (s1_adv) begin
        angd_r   <= ang_rdata;
        win_r[0] <= win_r[3];
        win_r[1] <= win_r[4];
        win_r[2] <= win_r[5];
        win_r[3] <= up;
        win_r[4] <= mid;
        win_r[5] <= s1_item_r.mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= item;
      s1_addr_r <= rd_addr;
    end
    if (s1_adv && s1_item_r.emit) begin
      out_kept_r <= kept;
      out_row_r  <= s1_item_r.row;
      out_col_r  <= s1_item_r.col;
      out_last_r <= s1_item_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kept  = out_kept_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

// File: hw/rtl/canny_non_maxima_suppression_unit.sv
// The line buffer words of an accepted transaction are read at the accepting edge and
//   the result register is loaded when the item leaves the second stage; a pixel leaves
//   width+1 items after it came. Throughput: one item per cycle, set by the single read
//   and write port of each line buffer, while no waiting result stalls the second stage.
// Reset: rst_n is synchronous, active low; it clears counters, window and result valid and
//   loads 640 x 480. Line buffers are not cleared and no clearing pass runs.
// Depends on cnms_pkg, cnms_if, cnms_ram, cnms_scan_ctrl and cnms_suppress.
`default_nettype none

module canny_non_maxima_suppression_unit #(
  parameter int unsigned MAX_WIDTH = cnms_pkg::CNMS_MAX_WIDTH
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cnms_in_if.sink     in_if,
  cnms_out_if.source  out_if,
  cnms_cfg_if.sink    cfg_if
);
  import cnms_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  // The block is organized around two line buffer RAMs that share one address: a
  // magnitude RAM whose word holds rows y-1 and y-2 side by side, and an angle RAM
  // holding row y-1. An item reads its column when its transaction is accepted and
  // writes the column back when it leaves the second stage. The next item is taken no
  // earlier than that cycle, at the following column, so the read never meets the pending
  // write; a column is revisited only after the write has landed, because the width
  // is at least three and the input is held off while the second stage is stalled.
  // The one exception is the first item of a frame that follows a frame end at once:
  // it reads column zero while the last item's write to it is still pending, and the
  // stale word it gets only ever feeds neighbours of border pixels.

  logic             in_accept;
  logic             cfg_write;
  logic             restart;
  logic [CW-1:0]    rd_addr;
  scan_item_t       item;
  logic             wr_en;
  logic [CW-1:0]    wr_addr;
  logic [2*MAG_W-1:0] mag_wdata, mag_rdata;
  logic [ANG_W-1:0] ang_wdata, ang_rdata;
  logic             stage_ready;

  // Configuration writes are always taken; users issue them only while the block is idle.
  assign cfg_if.ready = 1'b1;
  assign cfg_write    = cfg_if.valid;

  assign in_if.ready = stage_ready;
  assign in_accept   = in_if.valid && stage_ready;

  // Position counters decide at acceptance whether the item emits a pixel and whether
  // that pixel sits on the frame border or ends the frame.
  cnms_scan_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_write (cfg_write),
    .cfg_index (cfg_if.index),
    .cfg_data  (cfg_if.data),
    .in_accept (in_accept),
    .in_cmd    (in_if.cmd),
    .in_mag    (in_if.grad_magnitude),
    .in_ang    (in_if.grad_angle),
    .rd_addr   (rd_addr),
    .item      (item),
    .restart   (restart)
  );

  cnms_ram #(
    .WIDTH (2 * MAG_W),
    .DEPTH (MAX_WIDTH)
  ) u_mag_rows (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (mag_wdata),
    .re    (in_accept),
    .raddr (rd_addr),
    .rdata (mag_rdata)
  );

  cnms_ram #(
    .WIDTH (ANG_W),
    .DEPTH (MAX_WIDTH)
  ) u_ang_row (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (ang_wdata),
    .re    (in_accept),
    .raddr (rd_addr),
    .rdata (ang_rdata)
  );

  // Second stage: window shift, direction fold, compare, and the result register that
  // lets the next item enter while a finished result waits to be taken.
  cnms_suppress #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_suppress (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (restart),
    .in_accept (in_accept),
    .in_ready  (stage_ready),
    .item      (item),
    .rd_addr   (rd_addr),
    .mag_rdata (mag_rdata),
    .ang_rdata (ang_rdata),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .mag_wdata (mag_wdata),
    .ang_wdata (ang_wdata),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_kept  (out_if.kept_magnitude),
    .out_row   (out_if.out_row),
    .out_col   (out_if.out_col),
    .out_last  (out_if.frame_last)
  );

endmodule

`default_nettype wire

// File: hw/rtl/cnms_checker.sv
// Port-level checks of the suppression unit over time, bound to the top level.
// Depends on cnms_pkg for the payload widths.
`default_nettype none

module cnms_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [cnms_pkg::MAG_W-1:0]   kept_magnitude,
  input wire logic [cnms_pkg::ROW_W-1:0]   out_row,
  input wire logic [cnms_pkg::COL_W-1:0]   out_col,
  input wire logic                         frame_last
);
  import cnms_pkg::*;

  // A waiting result holds still until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(kept_magnitude) &&
    $stable(out_row) && $stable(out_col) && $stable(frame_last))
    else $error("result changed while stalled");

  // A fresh result follows an input via the stage and result registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without an input transaction two cycles earlier");

  // The frame end restarts the window, so nothing follows it at once.
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && frame_last |=> !out_valid)
    else $error("result directly after the frame end");

  // The last pixel is a corner away from the first row and column.
  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_last |-> (out_row != '0) && (out_col != '0))
    else $error("frame end flagged on the first row or column");

endmodule

bind canny_non_maxima_suppression_unit cnms_checker u_cnms_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .kept_magnitude (out_if.kept_magnitude),
  .out_row        (out_if.out_row),
  .out_col        (out_if.out_col),
  .frame_last     (out_if.frame_last)
);

`default_nettype wire
